### sv/cpu8alu_pkg.sv
// types and constants shared by the 8-bit cpu alu block
// no dependencies; imported by cpu8alu_exec and cpu8_alu_with_flags_core
`default_nettype none

package cpu8alu_pkg;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_ADC   = 4'd1,
		CMD_SBC   = 4'd2,
		CMD_AND   = 4'd3,
		CMD_XOR   = 4'd4,
		CMD_CP    = 4'd5,
		CMD_INC8  = 4'd6,
		CMD_DEC8  = 4'd7,
		CMD_RLCA  = 4'd8,
		CMD_RLA   = 4'd9,
		CMD_RL    = 4'd10,
		CMD_BIT   = 4'd11,
		CMD_ADD16 = 4'd12,
		CMD_INC16 = 4'd13,
		CMD_DEC16 = 4'd14
	} cmd_t;

	// flag bit positions in the 4-bit flag word
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;

	typedef struct packed {
		logic [3:0]        cmd;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
		logic [2:0]        bit_index;
		logic [3:0]        flags;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic [3:0]        flags;
	} alu_rsp_t;

endpackage

`default_nettype wire

### sv/cpu8_alu_with_flags_core.sv
// top level of the 8-bit cpu alu: input register, datapath, result register
// depends on cpu8alu_pkg and cpu8alu_exec
//
// usage:
//   input channel: in_valid / in_stall with cmd, operand_a, operand_b,
//   bit_index and flags_in. an item is taken at a clock edge where in_valid
//   is high and in_stall is low.
//   output channel: out_valid / out_stall with result and flags_out, taken
//   the same way. every item gives exactly one result item, in order.
//   path: an accepted item passes the input register, then the datapath
//   into the result register, before it is offered at the output.
//   throughput: one item per cycle while out_stall stays low; the datapath is a
//   single pass of 8- and 16-bit adders between the two registers.
//   stall: while the result register holds an untaken item under out_stall,
//   the input register still fills once; in_stall rises only when both
//   stages are full, so nothing is dropped.
//   reset: arst_n low clears both stage valid bits at once; no item is
//   pending after reset.
`default_nettype none

module cpu8_alu_with_flags_core
	import cpu8alu_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [3:0]          cmd,
	input  wire [WORD_W-1:0]   operand_a,
	input  wire [WORD_W-1:0]   operand_b,
	input  wire [2:0]          bit_index,
	input  wire [3:0]          flags_in,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [WORD_W-1:0]  result,
	output logic [3:0]         flags_out
);

	logic     valid_s1;
	alu_req_t req_s1;
	logic     valid_s2;
	alu_rsp_t rsp_s2;
	alu_rsp_t rsp_comb;
	logic     s2_blocked;
	logic     s1_load;

	assign s2_blocked = valid_s2 && out_stall;
	assign in_stall   = valid_s1 && s2_blocked;
	assign s1_load    = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			req_s1.cmd       <= cmd;
			req_s1.operand_a <= operand_a;
			req_s1.operand_b <= operand_b;
			req_s1.bit_index <= bit_index;
			req_s1.flags     <= flags_in;
		end
	end

	cpu8alu_exec u_exec (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!s2_blocked) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!s2_blocked && valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign out_valid = valid_s2;
	assign result    = rsp_s2.result;
	assign flags_out = rsp_s2.flags;

	// an item taken at the input lands in the first stage
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item missing from first stage");

	// a first-stage item moves on whenever the result register is free
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_blocked |=> valid_s2)
		else $error("first-stage item lost on its way to the result register");

	// backpressure only when both stages hold items
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with a free stage");

	// the first stage empties only by handing its item on
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s2_blocked |=> valid_s1 && $stable(req_s1))
		else $error("first-stage item changed while held");

endmodule

`default_nettype wire

### sv/cpu8alu_exec.sv
// combinational datapath of the 8-bit cpu alu: result and new z n h c flags
// depends on cpu8alu_pkg
`default_nettype none

module cpu8alu_exec
	import cpu8alu_pkg::*;
(
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	always_comb begin
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic              cin;
		logic              c_add;
		logic              c_sub;
		logic [BYTE_W:0]   sum9;
		logic [4:0]        hsum;
		logic [BYTE_W:0]   dif9;
		logic [4:0]        hdif;
		logic [WORD_W:0]   sum17;
		logic [12:0]       hsum13;
		logic [BYTE_W-1:0] r8;
		logic [WORD_W-1:0] res;
		logic [3:0]        f;

		a      = req.operand_a[BYTE_W-1:0];
		b      = req.operand_b[BYTE_W-1:0];
		cin    = req.flags[FLAG_C];
		c_add  = (cmd_t'(req.cmd) == CMD_ADC) ? cin : 1'b0;
		c_sub  = (cmd_t'(req.cmd) == CMD_SBC) ? cin : 1'b0;
		sum9   = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, c_add};
		hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_add};
		dif9   = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, c_sub};
		hdif   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sub};
		sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
		hsum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
		r8     = '0;
		res    = req.operand_a;
		f      = req.flags;

		case (req.cmd)
			CMD_ADD, CMD_ADC: begin
				r8 = sum9[BYTE_W-1:0];
				res = {8'd0, r8};
				f = '0;
				f[FLAG_Z] = (r8 == '0);
				f[FLAG_H] = hsum[4];
				f[FLAG_C] = sum9[BYTE_W];
			end
			CMD_SBC, CMD_CP: begin
				r8 = dif9[BYTE_W-1:0];
				// compare keeps the operand, only the flags change
				res = (cmd_t'(req.cmd) == CMD_CP) ? req.operand_a : {8'd0, r8};
				f = '0;
				f[FLAG_Z] = (r8 == '0);
				f[FLAG_N] = 1'b1;
				f[FLAG_H] = hdif[4];
				f[FLAG_C] = dif9[BYTE_W];
			end
			CMD_AND: begin
				r8 = a & b;
				res = {8'd0, r8};
				f = '0;
				f[FLAG_Z] = (r8 == '0);
				f[FLAG_H] = 1'b1;
			end
			CMD_XOR: begin
				r8 = a ^ b;
				res = {8'd0, r8};
				f = '0;
				f[FLAG_Z] = (r8 == '0);
			end
			CMD_INC8: begin
				r8 = a + 8'd1;
				res = {8'd0, r8};
				f[FLAG_Z] = (r8 == '0);
				f[FLAG_N] = 1'b0;
				f[FLAG_H] = (a[3:0] == 4'hF);
			end
			CMD_DEC8: begin
				r8 = a - 8'd1;
				res = {8'd0, r8};
				f[FLAG_Z] = (r8 == '0);
				f[FLAG_N] = 1'b1;
				f[FLAG_H] = (a[3:0] == 4'h0);
			end
			CMD_RLCA: begin
				r8 = {a[6:0], a[7]};
				res = {8'd0, r8};
				f = '0;
				f[FLAG_C] = a[7];
			end
			CMD_RLA, CMD_RL: begin
				r8 = {a[6:0], cin};
				res = {8'd0, r8};
				f = '0;
				f[FLAG_C] = a[7];
				f[FLAG_Z] = (cmd_t'(req.cmd) == CMD_RL) && (r8 == '0);
			end
			CMD_BIT: begin
				f[FLAG_Z] = ~a[req.bit_index];
				f[FLAG_N] = 1'b0;
				f[FLAG_H] = 1'b1;
			end
			CMD_ADD16: begin
				res = sum17[WORD_W-1:0];
				f[FLAG_N] = 1'b0;
				f[FLAG_H] = hsum13[12];
				f[FLAG_C] = sum17[WORD_W];
			end
			CMD_INC16: begin
				res = req.operand_a + 16'd1;
			end
			CMD_DEC16: begin
				res = req.operand_a - 16'd1;
			end
			// unused code passes operand and flags through
			default: begin
				res = req.operand_a;
				f = req.flags;
			end
		endcase

		rsp.result = res;
		rsp.flags  = f;
	end

endmodule

`default_nettype wire

### test/cpu8_alu_with_flags_checker.sv
// result checker for the 8-bit cpu alu: watches both channels, predicts each result
// depends on cpu8alu_pkg; instantiated beside the block by cpu8_alu_with_flags_core_tb
`timescale 1ns / 1ps

module cpu8_alu_with_flags_checker
	import cpu8alu_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire [3:0]         cmd,
	input  wire [WORD_W-1:0]  operand_a,
	input  wire [WORD_W-1:0]  operand_b,
	input  wire [2:0]         bit_index,
	input  wire [3:0]         flags_in,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire [WORD_W-1:0]  result,
	input  wire [3:0]         flags_out,
	output int                err_count,
	output int                pending_cnt,
	output int                checked_cnt
);

	typedef struct packed {
		logic [3:0] op;
		alu_rsp_t   rsp;
	} alu_item_t;

	alu_item_t pending_results[$];

	function automatic alu_rsp_t alu_outcome(input logic [3:0] op, input logic [15:0] a16,
		input logic [15:0] b16, input logic [2:0] bidx, input logic [3:0] fin);
		alu_rsp_t o;
		logic [7:0] a8;
		logic [7:0] b8;
		logic cin;
		logic c;
		logic [8:0] w9;
		logic [4:0] w5;
		logic [16:0] w17;
		logic [12:0] w13;
		a8 = a16[7:0];
		b8 = b16[7:0];
		cin = fin[FLAG_C];
		o.result = a16;
		o.flags = fin;
		case (op)
		CMD_ADD, CMD_ADC: begin
			c = (op == CMD_ADC) ? cin : 1'b0;
			w9 = {1'b0, a8} + {1'b0, b8} + {8'h00, c};
			w5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, c};
			o.result = {8'h00, w9[7:0]};
			o.flags = '0;
			o.flags[FLAG_Z] = (w9[7:0] == 8'h00);
			o.flags[FLAG_H] = w5[4];
			o.flags[FLAG_C] = w9[8];
		end
		CMD_SBC, CMD_CP: begin
			// borrow shows up as the sign bit of the widened difference
			c = (op == CMD_SBC) ? cin : 1'b0;
			w9 = {1'b0, a8} - {1'b0, b8} - {8'h00, c};
			w5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, c};
			if (op == CMD_SBC)
				o.result = {8'h00, w9[7:0]};
			o.flags = '0;
			o.flags[FLAG_Z] = (w9[7:0] == 8'h00);
			o.flags[FLAG_N] = 1'b1;
			o.flags[FLAG_H] = w5[4];
			o.flags[FLAG_C] = w9[8];
		end
		CMD_AND: begin
			o.result = {8'h00, a8 & b8};
			o.flags = '0;
			o.flags[FLAG_Z] = ((a8 & b8) == 8'h00);
			o.flags[FLAG_H] = 1'b1;
		end
		CMD_XOR: begin
			o.result = {8'h00, a8 ^ b8};
			o.flags = '0;
			o.flags[FLAG_Z] = ((a8 ^ b8) == 8'h00);
		end
		CMD_INC8, CMD_DEC8: begin
			o.result = (op == CMD_INC8) ? {8'h00, a8 + 8'd1} : {8'h00, a8 - 8'd1};
			o.flags = '0;
			o.flags[FLAG_C] = fin[FLAG_C];
			o.flags[FLAG_Z] = (o.result[7:0] == 8'h00);
			o.flags[FLAG_N] = (op == CMD_DEC8);
			o.flags[FLAG_H] = (op == CMD_INC8) ? (a8[3:0] == 4'hF) : (a8[3:0] == 4'h0);
		end
		CMD_RLCA: begin
			o.result = {8'h00, a8[6:0], a8[7]};
			o.flags = '0;
			o.flags[FLAG_C] = a8[7];
		end
		CMD_RLA, CMD_RL: begin
			o.result = {8'h00, a8[6:0], cin};
			o.flags = '0;
			o.flags[FLAG_C] = a8[7];
			if (op == CMD_RL)
				o.flags[FLAG_Z] = (o.result[7:0] == 8'h00);
		end
		CMD_BIT: begin
			o.flags = '0;
			o.flags[FLAG_C] = fin[FLAG_C];
			o.flags[FLAG_H] = 1'b1;
			o.flags[FLAG_Z] = !a8[bidx];
		end
		CMD_ADD16: begin
			w17 = {1'b0, a16} + {1'b0, b16};
			w13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
			o.result = w17[15:0];
			o.flags = '0;
			o.flags[FLAG_Z] = fin[FLAG_Z];
			o.flags[FLAG_H] = w13[12];
			o.flags[FLAG_C] = w17[16];
		end
		CMD_INC16: o.result = a16 + 16'd1;
		CMD_DEC16: o.result = a16 - 16'd1;
		default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [3:0] op,
		input logic [15:0] got, input logic [15:0] want);
		$display("%0t ns: %s (cmd %0d): got %h, expected %h", $time, what, op, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		alu_item_t head;
		if (!arst_n) begin
			pending_results.delete();
			pending_cnt <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no item pending", 4'h0, result, 16'h0000);
				end else begin
					head = pending_results.pop_front();
					if (result !== head.rsp.result)
						report_mismatch("result field", head.op, result, head.rsp.result);
					if (flags_out !== head.rsp.flags)
						report_mismatch("flags field", head.op, {12'h000, flags_out},
							{12'h000, head.rsp.flags});
					checked_cnt++;
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back('{op: cmd,
					rsp: alu_outcome(cmd, operand_a, operand_b, bit_index, flags_in)});
			pending_cnt <= pending_results.size();
		end
	end

endmodule

### test/cpu8_alu_with_flags_core_tb.sv
// testbench top for cpu8_alu_with_flags_core: clock, reset, item stimulus and verdict
// depends on cpu8alu_pkg, the block itself and cpu8_alu_with_flags_checker
`timescale 1ns / 1ps

module cpu8_alu_with_flags_core_tb;
	import cpu8alu_pkg::*;

	localparam logic [3:0] CMD_UNUSED = 4'd15;
	localparam int PHASE_ITEMS = 300;
	localparam int LONG_HOLD = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] cmd;
	logic [WORD_W-1:0] operand_a;
	logic [WORD_W-1:0] operand_b;
	logic [2:0] bit_index;
	logic [3:0] flags_in;
	logic out_valid;
	logic out_stall;
	logic [WORD_W-1:0] result;
	logic [3:0] flags_out;

	int err_count;
	int pending_cnt;
	int checked_cnt;
	int items_sent = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	cpu8_alu_with_flags_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.bit_index (bit_index),
		.flags_in  (flags_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.flags_out (flags_out)
	);

	cpu8_alu_with_flags_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.bit_index   (bit_index),
		.flags_in    (flags_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.flags_out   (flags_out),
		.err_count   (err_count),
		.pending_cnt (pending_cnt),
		.checked_cnt (checked_cnt)
	);

	// receiver: random stall, or a long hold whenever hold_seq moves
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results still pending",
				WATCHDOG_LIMIT, pending_cnt);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [3:0] op, input logic [15:0] a, input logic [15:0] b,
		input logic [2:0] bidx, input logic [3:0] fl);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		bit_index <= bidx;
		flags_in <= fl;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] edge_byte;
		case ($urandom_range(7))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h0F;
		3: return 8'h10;
		4: return 8'h7F;
		5: return 8'h80;
		6: return 8'hF0;
		default: return 8'h01;
		endcase
	endfunction

	function automatic logic [15:0] random_word;
		case ($urandom_range(3))
		0, 1: return 16'($urandom);
		2: return {8'($urandom), edge_byte()};
		default: return {edge_byte(), edge_byte()};
		endcase
	endfunction

	task automatic send_random;
		send_item(4'($urandom_range(15)), random_word(), random_word(),
			3'($urandom_range(7)), 4'($urandom_range(15)));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_ADD;
		operand_a <= '0;
		operand_b <= '0;
		bit_index <= '0;
		flags_in <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners of every operation, upper bytes set where they must be ignored
		send_item(CMD_ADD,   16'hA5FF, 16'h5A01, 3'd0, 4'b0000);
		send_item(CMD_ADD,   16'h0000, 16'h0000, 3'd0, 4'b1111);
		send_item(CMD_ADC,   16'h000F, 16'h0000, 3'd0, 4'b0001);
		send_item(CMD_ADC,   16'hFFFF, 16'hFFFF, 3'd7, 4'b0001);
		send_item(CMD_SBC,   16'h0000, 16'h0000, 3'd0, 4'b0001);
		send_item(CMD_SBC,   16'h1210, 16'h3401, 3'd0, 4'b0000);
		send_item(CMD_AND,   16'hFFF0, 16'hFF0F, 3'd0, 4'b1111);
		send_item(CMD_XOR,   16'h12C3, 16'h34C3, 3'd0, 4'b0000);
		send_item(CMD_CP,    16'hBE42, 16'h0042, 3'd0, 4'b0001);
		send_item(CMD_CP,    16'h0010, 16'hFF01, 3'd0, 4'b0000);
		send_item(CMD_INC8,  16'hABFF, 16'h0000, 3'd0, 4'b0001);
		send_item(CMD_INC8,  16'h000F, 16'h0000, 3'd0, 4'b0000);
		send_item(CMD_DEC8,  16'h0001, 16'h0000, 3'd0, 4'b0000);
		send_item(CMD_DEC8,  16'hFF00, 16'h0000, 3'd0, 4'b0001);
		send_item(CMD_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1110);
		send_item(CMD_RLA,   16'h0080, 16'h0000, 3'd0, 4'b0001);
		send_item(CMD_RLA,   16'h0000, 16'h0000, 3'd0, 4'b1000);
		send_item(CMD_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000);
		send_item(CMD_BIT,   16'hC37F, 16'h0000, 3'd7, 4'b0001);
		send_item(CMD_BIT,   16'h0001, 16'h0000, 3'd0, 4'b1000);
		send_item(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b1000);
		send_item(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b0111);
		send_item(CMD_INC16, 16'hFFFF, 16'h1234, 3'd0, 4'b1010);
		send_item(CMD_DEC16, 16'h0000, 16'h1234, 3'd0, 4'b0101);
		send_item(CMD_UNUSED, 16'hBEEF, 16'hCAFE, 3'd5, 4'b1001);
		drain_results();

		// idle/stall mixes: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 64 : (phase == 3) ? 31 : 0;
			recv_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 31 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long output hold while items keep coming, so in_stall has to rise
				if (i == 100 && (phase == 0 || phase == 3))
					hold_seq <= hold_seq + 1;
				send_random();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("%0d items sent, %0d results checked: directed corners of all operations,",
			items_sent, checked_cnt);
		$display("random items under four idle/stall mixes with two long output holds");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
sv/cpu8alu_pkg.sv
sv/cpu8alu_exec.sv
sv/cpu8_alu_with_flags_core.sv
test/cpu8_alu_with_flags_checker.sv
test/cpu8_alu_with_flags_core_tb.sv
